[src/hse_pkg.sv]
// Shared types and constants for the heap sort engine.
// Used by the channel interfaces, the element RAM, the core and the checker.
package hse_pkg;

  // Width of one element and default store depth.
  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 64;

  // One signed element as it moves through the block.
  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

[src/hse_if.sv]
// Valid/ready channel interfaces for the heap sort engine.
// Depends on hse_pkg for the element type.

// Input channel: one element per beat, last marks the end of a set.
interface hse_in_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Output channel: one sorted element per beat.
interface hse_out_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t sorted_value;
  logic  final_flag;
  logic  overflowed;

  modport source (output valid, output sorted_value, output final_flag,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input final_flag,
                  input overflowed, output ready);
endinterface

[src/hse_ram.sv]
// Element store: one write port and one read port with registered read data.
// Depends on hse_pkg for the element type.
module hse_ram import hse_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  elem_t         wdata,
  input  logic [AW-1:0] raddr,
  output elem_t         rdata
);

  elem_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data available the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/heap_sort_engine_core.sv]
// Heap sort engine top level: load, heap build, in-place sort, ordered emit.
// Depends on hse_pkg, the channel interfaces in hse_if.sv and hse_ram.
//
//   channel   dir  beat payload                          handshake
//   items     in   value, last                           valid/ready
//   results   out  sorted_value, final_flag, overflowed  valid/ready
//
// Loading stores one element per beat; items is ready only while loading.
// After the last beat, build and sort run through one RAM read port and one
// comparator: each sift-down fetches the root, then per level reads the left
// and right child, writes a larger child up and moves the value down; each
// root swap reads the root and the last slot and writes each into the other.
// Each result is read, registered and held on results until it is taken.
// Reset (synchronous, rst high) clears the element count and the overflow mark.
module heap_sort_engine_core import hse_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  hse_in_if.sink    items,
  hse_out_if.source results
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_BUILD      = 4'd1;
  localparam logic [3:0] S_SIFT_START = 4'd2;
  localparam logic [3:0] S_SIFT_CUR   = 4'd3;
  localparam logic [3:0] S_SIFT_L     = 4'd4;
  localparam logic [3:0] S_SIFT_LC    = 4'd5;
  localparam logic [3:0] S_SIFT_RC    = 4'd6;
  localparam logic [3:0] S_SIFT_DEC   = 4'd7;
  localparam logic [3:0] S_SIFT_SW    = 4'd8;
  localparam logic [3:0] S_SORT       = 4'd9;
  localparam logic [3:0] S_SWP0       = 4'd10;
  localparam logic [3:0] S_SWP1       = 4'd11;
  localparam logic [3:0] S_SWP2       = 4'd12;
  localparam logic [3:0] S_EMIT_RD    = 4'd13;
  localparam logic [3:0] S_EMIT_LD    = 4'd14;
  localparam logic [3:0] S_EMIT_WAIT  = 4'd15;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [CW-1:0] hlen;
  logic [CW-1:0] bk;
  logic [AW-1:0] cur;
  logic [AW-1:0] big;
  elem_t         cur_val;
  elem_t         big_val;
  elem_t         tmp0;
  logic          sorting;
  logic [AW-1:0] idx;
  logic          out_valid;
  elem_t         out_value;
  logic          out_final;
  logic          out_ovf;

  // RAM port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  elem_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  elem_t         ram_rdata;

  logic          in_beat;
  logic          has_room;
  logic [CW-1:0] count_next;
  logic [AW+1:0] lc;
  logic [AW+1:0] rc;
  logic          lc_in;
  logic          rc_in;
  logic          gt;
  logic [3:0]    sift_ret;
  logic [CW-1:0] hlen_m1;

  hse_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and loading helpers.
  assign items.ready = (state == S_IDLE);
  assign in_beat     = items.valid && (state == S_IDLE);
  assign has_room    = count < CW'(DEPTH);
  assign count_next  = has_room ? count + CW'(1) : count;

  // Child indices and the shared comparator.
  assign lc       = {1'b0, cur, 1'b1};
  assign rc       = lc + (AW+2)'(1);
  assign lc_in    = lc < {1'b0, hlen};
  assign rc_in    = rc < {1'b0, hlen};
  assign gt       = ram_rdata > big_val;
  assign sift_ret = sorting ? S_SORT : S_BUILD;
  assign hlen_m1  = hlen - CW'(1);

  // RAM address and write selection per state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = big_val;
    ram_raddr = cur;
    case (state)
      S_IDLE: begin
        ram_we    = in_beat && has_room;
        ram_waddr = count[AW-1:0];
        ram_wdata = items.value;
      end
      S_SIFT_L:  ram_raddr = lc[AW-1:0];
      S_SIFT_LC: ram_raddr = rc[AW-1:0];
      S_SIFT_DEC: begin
        ram_we    = (big != cur);
        ram_waddr = cur;
        ram_wdata = big_val;
      end
      S_SIFT_SW: begin
        ram_we    = 1'b1;
        ram_waddr = big;
        ram_wdata = cur_val;
      end
      S_SORT:    ram_raddr = '0;
      S_SWP0:    ram_raddr = hlen_m1[AW-1:0];
      S_SWP1: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
      end
      S_SWP2: begin
        ram_we    = 1'b1;
        ram_waddr = hlen_m1[AW-1:0];
        ram_wdata = tmp0;
      end
      S_EMIT_RD: ram_raddr = idx;
      default: ram_raddr = cur;
    endcase
  end

  // Sequencer: load, build, sort by root swap and sift-down, then emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      sorting   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            count <= count_next;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (items.last) begin
              hlen    <= count_next;
              bk      <= count_next >> 1;
              sorting <= 1'b0;
              state   <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (bk != '0) begin
            cur   <= AW'(bk - CW'(1));
            bk    <= bk - CW'(1);
            state <= S_SIFT_START;
          end else begin
            sorting <= 1'b1;
            state   <= S_SORT;
          end
        end
        S_SIFT_START: state <= S_SIFT_CUR;
        S_SIFT_CUR: begin
          cur_val <= ram_rdata;
          big_val <= ram_rdata;
          big     <= cur;
          state   <= S_SIFT_L;
        end
        S_SIFT_L: begin
          state <= lc_in ? S_SIFT_LC : sift_ret;
        end
        S_SIFT_LC: begin
          if (gt) begin
            big     <= lc[AW-1:0];
            big_val <= ram_rdata;
          end
          state <= rc_in ? S_SIFT_RC : S_SIFT_DEC;
        end
        S_SIFT_RC: begin
          if (gt) begin
            big     <= rc[AW-1:0];
            big_val <= ram_rdata;
          end
          state <= S_SIFT_DEC;
        end
        S_SIFT_DEC: begin
          state <= (big == cur) ? sift_ret : S_SIFT_SW;
        end
        S_SIFT_SW: begin
          // The moving value keeps going down from the child's slot.
          cur     <= big;
          big_val <= cur_val;
          state   <= S_SIFT_L;
        end
        S_SORT: begin
          if (hlen > CW'(1)) begin
            state <= S_SWP0;
          end else begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_SWP0: begin
          tmp0  <= ram_rdata;
          state <= S_SWP1;
        end
        S_SWP1: state <= S_SWP2;
        S_SWP2: begin
          hlen  <= hlen_m1;
          cur   <= '0;
          state <= S_SIFT_START;
        end
        S_EMIT_RD: state <= S_EMIT_LD;
        S_EMIT_LD: begin
          out_value <= ram_rdata;
          out_final <= (CW'(idx) + CW'(1)) == count;
          out_ovf   <= ovf;
          out_valid <= 1'b1;
          state     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            if (out_final) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result beat.
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.final_flag   = out_final;
  assign results.overflowed   = out_ovf;

endmodule

[src/hse_checker.sv]
// Port-level checks for the heap sort engine, attached to the top by bind.
// Depends on hse_pkg for the element type.
module hse_checker import hse_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  in_last,
  input logic  out_valid,
  input logic  out_ready,
  input elem_t out_value,
  input logic  out_final
);

  elem_t prev_val;
  logic  mid_set;

  // Track the previous result of the set being emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_set <= 1'b0;
    end else if (out_valid && out_ready) begin
      prev_val <= out_value;
      mid_set  <= !out_final;
    end
  end

  // No input is taken while a result is on offer.
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // The beat that closes a set stops further loading.
  a_last_closes_set: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still ready after the last beat of a set");

  // Results within a set come out in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && mid_set) |-> (out_value >= prev_val))
    else $error("result smaller than the previous one in the set");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed or dropped");

endmodule

bind heap_sort_engine_core hse_checker u_hse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_last   (items.last),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.sorted_value),
  .out_final (results.final_flag)
);
